### sv/kmlp_pkg.sv
`timescale 1ns / 1ps

package kmlp_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_COORDS   = 8;
  localparam int COORD_W      = 16;
  localparam int CNT_W        = 17;
  localparam int SUM_W        = COORD_W + CNT_W;
  localparam int CHANGE_W     = 40;
  localparam int ITER_W       = 16;
  localparam int CL_W         = $clog2(MAX_CLUSTERS);
  localparam int NK_W         = 5;
  localparam int ND_W         = 4;
  localparam int CMD_W        = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 40;

  // c * (c - 2x) needs COORD_W + (COORD_W + 2) bits, one spare
  localparam int PROD_W  = 2 * COORD_W + 3;
  localparam int SCORE_W = PROD_W + $clog2(MAX_COORDS);
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SQSUM_W = SQ_W + $clog2(MAX_COORDS);

  localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};
  localparam logic [CHANGE_W-1:0] CHANGE_MAX = {CHANGE_W{1'b1}};
  localparam logic [ITER_W-1:0] PASS_MAX = {ITER_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POINT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COORDS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [MAX_COORDS-1:0] coord_vec_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [MAX_COORDS-1:0] sum_vec_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    sum_vec_t         sums;
  } acc_word_t;

  localparam int CENT_W = $bits(coord_vec_t);
  localparam int ACC_W  = $bits(acc_word_t);

endpackage

### sv/kmlp_ram.sv
`timescale 1ns / 1ps

module kmlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/kmlp_div.sv
`timescale 1ns / 1ps

module kmlp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  kmlp_pkg::sum_vec_t            dividend_i,
  input  logic [kmlp_pkg::CNT_W-1:0]    divisor_i,
  output logic                          done_o,
  output kmlp_pkg::coord_vec_t          quot_o
);

  localparam int IT_W = $clog2(kmlp_pkg::SUM_W + 1);
  localparam int REM_W = kmlp_pkg::CNT_W + 1;

  logic                          busy_q;
  logic                          done_q;
  logic [IT_W-1:0]               it_q;
  logic [kmlp_pkg::CNT_W-1:0]    div_q;
  logic [kmlp_pkg::MAX_COORDS-1:0] neg_q;
  logic [kmlp_pkg::SUM_W-1:0]    mag_q [kmlp_pkg::MAX_COORDS];
  logic [REM_W-1:0]              rem_q [kmlp_pkg::MAX_COORDS];
  logic [REM_W-1:0]              rem_sh [kmlp_pkg::MAX_COORDS];
  logic [kmlp_pkg::MAX_COORDS-1:0] ge;
  logic [kmlp_pkg::SUM_W-1:0]    qres [kmlp_pkg::MAX_COORDS];

  // one restoring step per cycle in every lane, on magnitudes
  always_comb begin
    for (int j = 0; j < kmlp_pkg::MAX_COORDS; j++) begin
      rem_sh[j] = {rem_q[j][REM_W-2:0], mag_q[j][kmlp_pkg::SUM_W-1]};
      ge[j] = (rem_sh[j] >= {1'b0, div_q});
      qres[j] = neg_q[j] ? (~mag_q[j] + 1'b1) : mag_q[j];
      quot_o[j] = qres[j][kmlp_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        if (it_q == IT_W'(kmlp_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        it_q <= it_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      for (int j = 0; j < kmlp_pkg::MAX_COORDS; j++) begin
        neg_q[j] <= dividend_i[j][kmlp_pkg::SUM_W-1];
        mag_q[j] <= dividend_i[j][kmlp_pkg::SUM_W-1] ? (~dividend_i[j] + 1'b1)
                                                     : dividend_i[j];
        rem_q[j] <= '0;
      end
    end else if (busy_q) begin
      for (int j = 0; j < kmlp_pkg::MAX_COORDS; j++) begin
        rem_q[j] <= ge[j] ? (rem_sh[j] - {1'b0, div_q}) : rem_sh[j];
        mag_q[j] <= {mag_q[j][kmlp_pkg::SUM_W-2:0], ge[j]};
      end
    end
  end

  assign done_o = done_q;

endmodule

### sv/kmeans_lloyd_pass_engine.sv
`timescale 1ns / 1ps

// Lloyd k-means pass engine, one transaction at a time. A load transaction writes one
// centroid row. A point transaction scans the centroids in use one per cycle from the
// centroid memory, eight coordinate lanes in parallel; after a read-modify-write of
// that cluster's sums and count its membership result is registered, and the block
// takes the next transaction once that result is loaded. An end-of-pass transaction
// forms sum / count for each centroid in use in the 33-step lane dividers and emits one
// result per centroid; the last one carries the saturated squared change and done. A
// stalled result is held until it is taken, and the block waits at its next result.
// Sums and counts read as zero after reset and after each pass through per-row valid flags.
module kmeans_lloyd_pass_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kmlp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kmlp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [3:0]                          centroid_slot_i,
  input  logic signed [15:0]                  coord_0_i,
  input  logic signed [15:0]                  coord_1_i,
  input  logic signed [15:0]                  coord_2_i,
  input  logic signed [15:0]                  coord_3_i,
  input  logic signed [15:0]                  coord_4_i,
  input  logic signed [15:0]                  coord_5_i,
  input  logic signed [15:0]                  coord_6_i,
  input  logic signed [15:0]                  coord_7_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [3:0]                          cluster_index_o,
  output logic signed [15:0]                  out_coord_0_o,
  output logic signed [15:0]                  out_coord_1_o,
  output logic signed [15:0]                  out_coord_2_o,
  output logic signed [15:0]                  out_coord_3_o,
  output logic signed [15:0]                  out_coord_4_o,
  output logic signed [15:0]                  out_coord_5_o,
  output logic signed [15:0]                  out_coord_6_o,
  output logic signed [15:0]                  out_coord_7_o,
  output logic [39:0]                         move_sq_o,
  output logic                                done_res_o,
  output logic                                last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_UPD_RD, S_UPD_WR, S_PT_OUT,
    S_E_RD, S_E_LAT, S_E_DIV, S_E_SQ, S_E_ACC, S_E_OUT
  } state_e;

  localparam int NL = kmlp_pkg::MAX_COORDS;
  localparam int NC = kmlp_pkg::MAX_CLUSTERS;

  state_e state_q;

  logic [kmlp_pkg::NK_W-1:0]     num_clusters_q;
  logic [kmlp_pkg::ND_W-1:0]     num_coords_q;
  logic [kmlp_pkg::ITER_W-1:0]   max_iter_q;
  logic [kmlp_pkg::CHANGE_W-1:0] thr_q;

  logic [kmlp_pkg::NK_W-1:0] nk;
  logic [kmlp_pkg::ND_W-1:0] nd;
  logic [kmlp_pkg::CL_W-1:0] nk_last;
  logic [NL-1:0]             lane_on;

  kmlp_pkg::coord_vec_t in_x;
  kmlp_pkg::coord_vec_t x_q;

  // centroid memory
  logic                       cent_we;
  logic [kmlp_pkg::CL_W-1:0]  cent_waddr;
  kmlp_pkg::coord_vec_t       cent_wdata;
  logic [kmlp_pkg::CL_W-1:0]  cent_raddr;
  kmlp_pkg::coord_vec_t       cent_rdata;

  // accumulator memory
  logic                       acc_we;
  logic [kmlp_pkg::CL_W-1:0]  acc_waddr;
  kmlp_pkg::acc_word_t        acc_wdata;
  logic [kmlp_pkg::CL_W-1:0]  acc_raddr;
  kmlp_pkg::acc_word_t        acc_rdata;
  kmlp_pkg::acc_word_t        acc_cur;
  logic [NC-1:0]              acc_vld_q;

  // scan pipeline
  logic [kmlp_pkg::CL_W-1:0]        iss_q;
  logic                             iss_act_q;
  logic                             v1_q, v2_q, v3_q;
  logic [kmlp_pkg::CL_W-1:0]        i1_q, i2_q, i3_q;
  logic signed [kmlp_pkg::PROD_W-1:0]  prod_d [NL];
  logic signed [kmlp_pkg::PROD_W-1:0]  prod_q [NL];
  logic signed [kmlp_pkg::SCORE_W-1:0] score_d;
  logic signed [kmlp_pkg::SCORE_W-1:0] score_q;
  logic signed [kmlp_pkg::SCORE_W-1:0] best_score_q;
  logic [kmlp_pkg::CL_W-1:0]        best_q;
  logic                             best_take;

  // end-of-pass datapath
  logic [kmlp_pkg::CL_W-1:0]        k_q;
  kmlp_pkg::coord_vec_t             old_q;
  kmlp_pkg::coord_vec_t             new_d;
  kmlp_pkg::coord_vec_t             new_q;
  logic [kmlp_pkg::CNT_W-1:0]       cnt_q;
  logic [kmlp_pkg::SQ_W-1:0]        sq_d [NL];
  logic [kmlp_pkg::SQ_W-1:0]        sq_q [NL];
  logic [kmlp_pkg::SQSUM_W-1:0]     sqsum;
  logic [kmlp_pkg::CHANGE_W:0]      change_tot;
  logic [kmlp_pkg::CHANGE_W-1:0]    change_q;
  logic [kmlp_pkg::ITER_W-1:0]      pass_q;
  logic [kmlp_pkg::ITER_W-1:0]      pass_d;
  logic                             done_d;
  logic                             div_start;
  logic                             div_done;
  kmlp_pkg::coord_vec_t             quot;

  // output register
  logic                             out_valid_q;
  logic [kmlp_pkg::CL_W-1:0]        out_idx_q;
  kmlp_pkg::coord_vec_t             out_coord_q;
  logic [kmlp_pkg::CHANGE_W-1:0]    out_change_q;
  logic                             out_done_q;
  logic                             out_last_q;
  logic                             out_free;
  logic                             out_load;
  logic                             in_acc;

  assign in_x[0] = coord_0_i;
  assign in_x[1] = coord_1_i;
  assign in_x[2] = coord_2_i;
  assign in_x[3] = coord_3_i;
  assign in_x[4] = coord_4_i;
  assign in_x[5] = coord_5_i;
  assign in_x[6] = coord_6_i;
  assign in_x[7] = coord_7_i;

  always_comb begin
    priority if (num_clusters_q == '0) begin
      nk = kmlp_pkg::NK_W'(1);
    end else if (num_clusters_q > kmlp_pkg::NK_W'(NC)) begin
      nk = kmlp_pkg::NK_W'(NC);
    end else begin
      nk = num_clusters_q;
    end
    priority if (num_coords_q == '0) begin
      nd = kmlp_pkg::ND_W'(1);
    end else if (num_coords_q > kmlp_pkg::ND_W'(NL)) begin
      nd = kmlp_pkg::ND_W'(NL);
    end else begin
      nd = num_coords_q;
    end
    nk_last = kmlp_pkg::CL_W'(nk - 1'b1);
    for (int j = 0; j < NL; j++) begin
      lane_on[j] = (kmlp_pkg::ND_W'(j) < nd);
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && (state_q == S_PT_OUT || state_q == S_E_OUT);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // memory port steering
  always_comb begin
    cent_we    = (in_acc && command_i == kmlp_pkg::CMD_LOAD) || (state_q == S_E_ACC);
    cent_waddr = (state_q == S_E_ACC) ? k_q : centroid_slot_i;
    cent_wdata = (state_q == S_E_ACC) ? new_q : in_x;
    cent_raddr = (state_q == S_SCAN) ? iss_q : k_q;

    acc_raddr  = (state_q == S_UPD_RD) ? best_q : k_q;
    acc_cur    = acc_vld_q[(state_q == S_UPD_WR) ? best_q : k_q] ? acc_rdata : '0;
    acc_waddr  = best_q;
    acc_wdata.cnt = acc_cur.cnt + 1'b1;
    for (int j = 0; j < NL; j++) begin
      acc_wdata.sums[j] = lane_on[j]
          ? acc_cur.sums[j] + {{(kmlp_pkg::SUM_W - kmlp_pkg::COORD_W){x_q[j][kmlp_pkg::COORD_W-1]}},
                               x_q[j]}
          : acc_cur.sums[j];
    end
    acc_we = (state_q == S_UPD_WR) && (acc_cur.cnt != kmlp_pkg::COUNT_LIMIT);
  end

  // score lanes: c * (c - 2x), unused lanes contribute nothing
  always_comb begin
    logic signed [kmlp_pkg::COORD_W+1:0] t;
    logic signed [kmlp_pkg::COORD_W+1:0] c;
    score_d = '0;
    for (int j = 0; j < NL; j++) begin
      c = {{2{cent_rdata[j][kmlp_pkg::COORD_W-1]}}, cent_rdata[j]};
      t = c - {x_q[j][kmlp_pkg::COORD_W-1], x_q[j], 1'b0};
      prod_d[j] = lane_on[j] ? (kmlp_pkg::PROD_W'(c) * kmlp_pkg::PROD_W'(t)) : '0;
      score_d = score_d + {{(kmlp_pkg::SCORE_W - kmlp_pkg::PROD_W){prod_q[j][kmlp_pkg::PROD_W-1]}},
                           prod_q[j]};
    end
    best_take = v3_q && ((i3_q == '0) || (score_q < best_score_q));
  end

  // new centroid, movement squares and change sum
  always_comb begin
    logic signed [kmlp_pkg::DIFF_W-1:0] diff;
    logic signed [kmlp_pkg::SQ_W-1:0]   sq_s;
    sqsum = '0;
    for (int j = 0; j < NL; j++) begin
      new_d[j] = (lane_on[j] && cnt_q != '0) ? quot[j] : old_q[j];
      diff = {new_d[j][kmlp_pkg::COORD_W-1], new_d[j]} - {old_q[j][kmlp_pkg::COORD_W-1], old_q[j]};
      sq_s = kmlp_pkg::SQ_W'(diff) * kmlp_pkg::SQ_W'(diff);
      sq_d[j] = sq_s;
      sqsum = sqsum + kmlp_pkg::SQSUM_W'(sq_q[j]);
    end
    change_tot = {1'b0, change_q} + (kmlp_pkg::CHANGE_W + 1)'(sqsum);
    pass_d = (pass_q == kmlp_pkg::PASS_MAX) ? pass_q : pass_q + 1'b1;
    done_d = (pass_d >= max_iter_q) || (change_q <= thr_q);
  end

  assign div_start = (state_q == S_E_LAT);

  kmlp_ram #(.WIDTH(kmlp_pkg::CENT_W), .DEPTH(NC)) u_cent_ram (
    .clk_i   (clk_i),
    .we_i    (cent_we),
    .waddr_i (cent_waddr),
    .wdata_i (cent_wdata),
    .raddr_i (cent_raddr),
    .rdata_o (cent_rdata)
  );

  kmlp_ram #(.WIDTH(kmlp_pkg::ACC_W), .DEPTH(NC)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  kmlp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_cur.sums),
    .divisor_i  (acc_cur.cnt),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_x;
    end
    for (int j = 0; j < NL; j++) begin
      prod_q[j] <= prod_d[j];
    end
    score_q <= score_d;
    if (best_take) begin
      best_score_q <= score_q;
    end
    if (state_q == S_E_LAT) begin
      old_q <= cent_rdata;
      cnt_q <= acc_cur.cnt;
    end
    if (state_q == S_E_SQ) begin
      new_q <= new_d;
      for (int j = 0; j < NL; j++) begin
        sq_q[j] <= sq_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      num_clusters_q <= kmlp_pkg::NK_W'(16);
      num_coords_q   <= kmlp_pkg::ND_W'(8);
      max_iter_q     <= kmlp_pkg::ITER_W'(100);
      thr_q          <= '0;
      acc_vld_q      <= '0;
      iss_q          <= '0;
      iss_act_q      <= 1'b0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      i1_q           <= '0;
      i2_q           <= '0;
      i3_q           <= '0;
      best_q         <= '0;
      k_q            <= '0;
      change_q       <= '0;
      pass_q         <= '0;
      out_valid_q    <= 1'b0;
      out_idx_q      <= '0;
      out_coord_q    <= '0;
      out_change_q   <= '0;
      out_done_q     <= 1'b0;
      out_last_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          kmlp_pkg::CFG_NUM_CLUSTERS:   num_clusters_q <= cfg_data_i[kmlp_pkg::NK_W-1:0];
          kmlp_pkg::CFG_NUM_COORDS:     num_coords_q   <= cfg_data_i[kmlp_pkg::ND_W-1:0];
          kmlp_pkg::CFG_MAX_ITERATIONS: max_iter_q     <= cfg_data_i[kmlp_pkg::ITER_W-1:0];
          kmlp_pkg::CFG_THRESHOLD:      thr_q          <= cfg_data_i[kmlp_pkg::CHANGE_W-1:0];
          default: ;
        endcase
      end

      if (!out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      v1_q <= (state_q == S_SCAN) && iss_act_q;
      i1_q <= iss_q;
      v2_q <= v1_q;
      i2_q <= i1_q;
      v3_q <= v2_q;
      i3_q <= i2_q;
      if (best_take) begin
        best_q <= i3_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (command_i)
              kmlp_pkg::CMD_POINT: begin
                iss_q     <= '0;
                iss_act_q <= 1'b1;
                state_q   <= S_SCAN;
              end
              kmlp_pkg::CMD_END: begin
                k_q      <= '0;
                change_q <= '0;
                state_q  <= S_E_RD;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (iss_act_q) begin
            if (iss_q == nk_last) begin
              iss_act_q <= 1'b0;
            end else begin
              iss_q <= iss_q + 1'b1;
            end
          end
          if (v3_q && i3_q == nk_last) begin
            state_q <= S_UPD_RD;
          end
        end
        S_UPD_RD: state_q <= S_UPD_WR;
        S_UPD_WR: begin
          if (acc_we) begin
            acc_vld_q[best_q] <= 1'b1;
          end
          state_q <= S_PT_OUT;
        end
        S_PT_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_idx_q    <= best_q;
            out_coord_q  <= '0;
            out_change_q <= '0;
            out_done_q   <= 1'b0;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_E_RD:  state_q <= S_E_LAT;
        S_E_LAT: state_q <= S_E_DIV;
        S_E_DIV: begin
          if (div_done) begin
            state_q <= S_E_SQ;
          end
        end
        S_E_SQ: state_q <= S_E_ACC;
        S_E_ACC: begin
          change_q <= change_tot[kmlp_pkg::CHANGE_W] ? kmlp_pkg::CHANGE_MAX
                                                     : change_tot[kmlp_pkg::CHANGE_W-1:0];
          state_q  <= S_E_OUT;
        end
        S_E_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= k_q;
            for (int j = 0; j < NL; j++) begin
              out_coord_q[j] <= lane_on[j] ? new_q[j] : '0;
            end
            if (k_q == nk_last) begin
              out_change_q <= change_q;
              out_done_q   <= done_d;
              out_last_q   <= 1'b1;
              pass_q       <= pass_d;
              acc_vld_q    <= '0;
              state_q      <= S_IDLE;
            end else begin
              out_change_q <= '0;
              out_done_q   <= 1'b0;
              out_last_q   <= 1'b0;
              k_q          <= k_q + 1'b1;
              state_q      <= S_E_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cluster_index_o = out_idx_q;
  assign out_coord_0_o   = out_coord_q[0];
  assign out_coord_1_o   = out_coord_q[1];
  assign out_coord_2_o   = out_coord_q[2];
  assign out_coord_3_o   = out_coord_q[3];
  assign out_coord_4_o   = out_coord_q[4];
  assign out_coord_5_o   = out_coord_q[5];
  assign out_coord_6_o   = out_coord_q[6];
  assign out_coord_7_o   = out_coord_q[7];
  assign move_sq_o       = out_change_q;
  assign done_res_o      = out_done_q;
  assign last_o          = out_last_q;

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_UPD_RD) |-> ({1'b0, best_q} < nk))
    else $error("winning centroid outside the clusters in use");

  a_div_before_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_E_SQ) |-> $past(div_done))
    else $error("centroid update used before the divide finished");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_IDLE && $past(state_q) == S_E_OUT) |-> (acc_vld_q == '0))
    else $error("accumulators not cleared at end of pass");

  a_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
      v3_q |-> (state_q == S_SCAN))
    else $error("score pipeline active outside a point scan");

endmodule

### sim/kmlp_checker.sv
`timescale 1ns / 1ps

module kmlp_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kmlp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kmlp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [1:0]                           command_i,
  input  logic [3:0]                           centroid_slot_i,
  input  logic [7:0][15:0]                     coords_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [3:0]                           cluster_index_i,
  input  logic [7:0][15:0]                     out_coords_i,
  input  logic [39:0]                          move_sq_i,
  input  logic                                 done_res_i,
  input  logic                                 last_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import kmlp_pkg::*;

  typedef struct {
    logic [3:0]       cluster;
    logic [7:0][15:0] crd;
    logic [39:0]      change;
    logic             done;
    logic             last;
  } km_result_t;

  km_result_t result_q[$];

  longint        centroid[MAX_CLUSTERS][MAX_COORDS];
  longint        csum[MAX_CLUSTERS][MAX_COORDS];
  longint        members[MAX_CLUSTERS];
  int            passes;
  logic [4:0]    nk_reg;
  logic [3:0]    nd_reg;
  logic [15:0]   iter_limit;
  logic [39:0]   thresh;

  function automatic int clusters_used();
    if (nk_reg == 0) return 1;
    if (nk_reg > MAX_CLUSTERS) return MAX_CLUSTERS;
    return int'(nk_reg);
  endfunction

  function automatic int coords_used();
    if (nd_reg == 0) return 1;
    if (nd_reg > MAX_COORDS) return MAX_COORDS;
    return int'(nd_reg);
  endfunction

  task automatic model_reset();
    passes = 0;
    nk_reg = 5'd16;
    nd_reg = 4'd8;
    iter_limit = 16'd100;
    thresh = '0;
    result_q.delete();
    for (int i = 0; i < MAX_CLUSTERS; i++) begin
      members[i] = 0;
      for (int j = 0; j < MAX_COORDS; j++) begin
        centroid[i][j] = 0;
        csum[i][j] = 0;
      end
    end
  endtask

  task automatic predict_transaction();
    int         nk;
    int         nd;
    longint     x[MAX_COORDS];
    longint     score;
    longint     best_score;
    int         best;
    longint     nv;
    longint     d;
    longint     change;
    km_result_t r;
    nk = clusters_used();
    nd = coords_used();
    for (int j = 0; j < MAX_COORDS; j++) x[j] = longint'($signed(coords_i[j]));
    case (command_i)
      CMD_LOAD: begin
        for (int j = 0; j < MAX_COORDS; j++) centroid[centroid_slot_i][j] = x[j];
      end
      CMD_POINT: begin
        best = 0;
        best_score = 0;
        for (int i = 0; i < nk; i++) begin
          score = 0;
          for (int j = 0; j < nd; j++)
            score += centroid[i][j] * centroid[i][j] - 2 * x[j] * centroid[i][j];
          if (i == 0 || score < best_score) begin
            best_score = score;
            best = i;
          end
        end
        if (members[best] < COUNT_LIMIT) begin
          members[best]++;
          for (int j = 0; j < nd; j++) csum[best][j] += x[j];
        end
        r.cluster = 4'(best);
        r.crd = '0;
        r.change = '0;
        r.done = 1'b0;
        r.last = 1'b1;
        result_q = {result_q, r};
      end
      CMD_END: begin
        change = 0;
        for (int i = 0; i < nk; i++) begin
          for (int j = 0; j < nd; j++) begin
            nv = centroid[i][j];
            if (members[i] > 0) nv = csum[i][j] / members[i];
            d = (nv > centroid[i][j]) ? nv - centroid[i][j] : centroid[i][j] - nv;
            centroid[i][j] = nv;
            change += d * d;
            if (change > longint'(CHANGE_MAX)) change = longint'(CHANGE_MAX);
          end
        end
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          members[i] = 0;
          for (int j = 0; j < MAX_COORDS; j++) csum[i][j] = 0;
        end
        if (passes < PASS_MAX) passes++;
        for (int i = 0; i < nk; i++) begin
          r.cluster = 4'(i);
          for (int j = 0; j < MAX_COORDS; j++)
            r.crd[j] = (j < nd) ? 16'(centroid[i][j]) : 16'd0;
          r.change = '0;
          r.done = 1'b0;
          r.last = 1'b0;
          if (i + 1 == nk) begin
            r.change = change[39:0];
            r.done = (passes >= iter_limit) || (change <= longint'(thresh));
            r.last = 1'b1;
          end
          result_q = {result_q, r};
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_result();
    km_result_t e;
    if (result_q.size() == 0) begin
      $display("%0t: unexpected result, cluster %0d", $time, cluster_index_i);
      fail_count_o++;
      return;
    end
    e = result_q.pop_front();
    if (cluster_index_i !== e.cluster) begin
      $display("%0t: cluster_index expected %0d actual %0d", $time, e.cluster,
               cluster_index_i);
      fail_count_o++;
    end
    for (int j = 0; j < MAX_COORDS; j++)
      if (out_coords_i[j] !== e.crd[j]) begin
        $display("%0t: out_coord_%0d expected %h actual %h", $time, j, e.crd[j],
                 out_coords_i[j]);
        fail_count_o++;
      end
    if (move_sq_i !== e.change) begin
      $display("%0t: move_sq expected %h actual %h", $time, e.change, move_sq_i);
      fail_count_o++;
    end
    if (done_res_i !== e.done) begin
      $display("%0t: done_res expected %b actual %b", $time, e.done, done_res_i);
      fail_count_o++;
    end
    if (last_i !== e.last) begin
      $display("%0t: last expected %b actual %b", $time, e.last, last_i);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      model_reset();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NUM_CLUSTERS:   nk_reg = cfg_data_i[4:0];
          CFG_NUM_COORDS:     nd_reg = cfg_data_i[3:0];
          CFG_MAX_ITERATIONS: iter_limit = cfg_data_i[15:0];
          CFG_THRESHOLD:      thresh = cfg_data_i[39:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) predict_transaction();
      pending_o <= result_q.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kmlp_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              command;
  logic [3:0]              slot;
  logic [7:0][15:0]        pt_crd;
  logic                    out_valid;
  logic                    out_stall;
  logic [3:0]              cluster_index;
  wire  [7:0][15:0]        res_crd;
  logic [39:0]             move_sq;
  logic                    done_res;
  logic                    last;
  int                      fail_count;
  int                      pending;
  int                      items_sent;
  bit                      hold_done;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 100;

  kmeans_lloyd_pass_engine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .centroid_slot_i(slot),
    .coord_0_i(pt_crd[0]), .coord_1_i(pt_crd[1]), .coord_2_i(pt_crd[2]),
    .coord_3_i(pt_crd[3]), .coord_4_i(pt_crd[4]), .coord_5_i(pt_crd[5]),
    .coord_6_i(pt_crd[6]), .coord_7_i(pt_crd[7]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .cluster_index_o(cluster_index),
    .out_coord_0_o(res_crd[0]), .out_coord_1_o(res_crd[1]), .out_coord_2_o(res_crd[2]),
    .out_coord_3_o(res_crd[3]), .out_coord_4_o(res_crd[4]), .out_coord_5_o(res_crd[5]),
    .out_coord_6_o(res_crd[6]), .out_coord_7_o(res_crd[7]),
    .move_sq_o(move_sq), .done_res_o(done_res), .last_o(last)
  );

  kmlp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .command_i(command), .centroid_slot_i(slot), .coords_i(pt_crd),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .cluster_index_i(cluster_index), .out_coords_i(res_crd),
    .move_sq_i(move_sq), .done_res_i(done_res), .last_i(last),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit no_idle();
    return items_sent >= 90 && items_sent < 115;
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [3:0] s, logic [7:0][15:0] c);
    while (!no_idle() && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    slot     <= s;
    pt_crd   <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0][15:0] rand_coords();
    logic [7:0][15:0] c;
    for (int j = 0; j < 8; j++) c[j] = $urandom;
    return c;
  endfunction

  function automatic logic [7:0][15:0] fill_coords(logic [15:0] v);
    logic [7:0][15:0] c;
    for (int j = 0; j < 8; j++) c[j] = v;
    return c;
  endfunction

  // mostly points clustered loosely, some loads, end-of-pass and ignored commands
  task automatic random_phase(int n);
    int               pick;
    logic [7:0][15:0] c;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        c = rand_coords();
        if ($urandom_range(1) == 1)
          for (int j = 0; j < 8; j++) c[j] = $signed(c[j]) >>> $urandom_range(8, 2);
        send_item(CMD_POINT, 4'($urandom), c);
      end else if (pick < 85) begin
        send_item(CMD_LOAD, 4'($urandom), rand_coords());
      end else if (pick < 95) begin
        send_item(CMD_END, 4'($urandom), rand_coords());
      end else begin
        send_item(2'd3, 4'($urandom), rand_coords());
      end
    end
    send_item(CMD_END, 4'($urandom), rand_coords());
  endtask

  task automatic set_all(logic [4:0] nk, logic [3:0] nd, logic [15:0] it, logic [39:0] th);
    write_reg(CFG_NUM_CLUSTERS, CFG_DATA_W'(nk));
    write_reg(CFG_NUM_COORDS, CFG_DATA_W'(nd));
    write_reg(CFG_MAX_ITERATIONS, CFG_DATA_W'(it));
    write_reg(CFG_THRESHOLD, th);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && items_sent >= 70) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= !no_idle() && ($urandom_range(99) < 7);
        @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL kmeans_lloyd_pass_engine");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0][15:0] c;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_LOAD;
    slot = '0;
    pt_crd = '0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every slot loaded, extremes, tie, ignored command, empty clusters
    set_all(5'd16, 4'd8, 16'd100, 40'd0);
    send_item(CMD_LOAD, 4'd0, fill_coords(16'h7FFF));
    send_item(CMD_LOAD, 4'd1, fill_coords(16'h8000));
    c = rand_coords();
    send_item(CMD_LOAD, 4'd2, c);
    send_item(CMD_LOAD, 4'd3, c);
    for (int s = 4; s < 16; s++) send_item(CMD_LOAD, 4'(s), rand_coords());
    send_item(CMD_POINT, 4'd0, fill_coords(16'h7FFF));
    send_item(CMD_POINT, 4'd0, fill_coords(16'h8000));
    send_item(CMD_POINT, 4'd0, c);
    send_item(CMD_POINT, 4'd0, fill_coords(16'h0000));
    send_item(2'd3, 4'd15, fill_coords(16'hFFFF));
    send_item(CMD_END, 4'd0, fill_coords(16'h0000));
    drain();

    // settings sweep, extremes and out-of-range values included
    set_all(5'd1, 4'd1, 16'd1, 40'hFF_FFFF_FFFF);
    random_phase(16);
    drain();
    set_all(5'd31, 4'd15, 16'd65535, 40'd0);
    random_phase(20);
    drain();
    set_all(5'd0, 4'd0, 16'd2, 40'($urandom));
    random_phase(16);
    drain();
    set_all(5'($urandom_range(16, 2)), 4'($urandom_range(8, 2)),
            16'($urandom_range(65535, 1)), {8'($urandom), 32'($urandom)});
    random_phase(30);
    drain();
    set_all(5'd16, 4'd8, 16'd3, 40'h10_0000);
    random_phase(21);
    drain();

    if (fail_count == 0) begin
      $display("PASS kmeans_lloyd_pass_engine");
    end else begin
      $display("FAIL kmeans_lloyd_pass_engine");
    end
    $finish;
  end

endmodule

### kmeans_lloyd_pass_engine.f
sv/kmlp_pkg.sv
sv/kmlp_ram.sv
sv/kmlp_div.sv
sv/kmeans_lloyd_pass_engine.sv
sim/kmlp_checker.sv
sim/testbench.sv
